FILE: hdl/rsti_pkg.sv
`timescale 1ns / 1ps

package rsti_pkg;

    // largest alphabet the core supports
    localparam int MAX_BASE_DEF = 16;

    // fixed field widths
    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 32;
    localparam int CFG_W   = 64;
    localparam int LEN_W   = 5;
    localparam int SYM_CNT = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_ALPHA_LOW  = 2'd0;
    localparam logic [1:0] CFG_ALPHA_HIGH = 2'd1;
    localparam logic [1:0] CFG_ALPHA_LEN  = 2'd2;

    // character codes
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;

    typedef logic [CHAR_W-1:0] t_sym;

endpackage

FILE: hdl/radix_string_to_integer_core.sv
`timescale 1ns / 1ps

// channel      | dir | tdata                     | tuser        | tlast
// -------------+-----+---------------------------+--------------+----------
// s_axis       | in  | [7:0] char_code           | -            | is_last
// m_axis       | out | [31:0] value (signed)     | [0] base_ok  | -
// cfg          | in  | we / index[1:0] / data[63:0], no read-back
//
// one character per cycle: a transfer lands in the input register and is
// parsed the next cycle by one 32x5 multiply-add plus a 16-way symbol compare
// the last character of a string loads the result register
// the input register keeps moving while a result waits, except when a last
// character finds the result register full and not being taken
// synchronous active-low reset clears parser state, alphabet and valid flags

module radix_string_to_integer_core
    import rsti_pkg::*;
#(
    parameter int MAX_BASE = MAX_BASE_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // [7:0] char_code
    input  logic [CHAR_W-1:0]         i_s_axis_tdata,
    input  logic                      i_s_axis_tlast,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // [31:0] value
    output logic signed [VALUE_W-1:0] o_m_axis_tdata,
    // [0] base_ok
    output logic                      o_m_axis_tuser,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    localparam int DIG_W = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;

    typedef enum logic [1:0] {
        PH_SPACE = 2'd0,
        PH_SIGN  = 2'd1,
        PH_DIGIT = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    // configuration
    logic [CFG_W-1:0] r_alpha_low;
    logic [CFG_W-1:0] r_alpha_high;
    logic [LEN_W-1:0] r_alpha_len;

    // input register
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;

    // parser state
    t_phase             r_phase;
    logic               r_neg;
    logic [VALUE_W-1:0] r_acc;

    // result register
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_ok;

    t_phase             n_phase;
    logic               n_neg;
    logic [VALUE_W-1:0] n_acc;

    t_sym               sym [SYM_CNT];
    logic               base_ok;
    logic               dig_hit;
    logic [DIG_W-1:0]   dig_val;
    logic               advance;
    logic               is_ws;

    always_comb begin
        for (int k = 0; k < SYM_CNT; k++) begin
            if (k < 8) begin
                sym[k] = r_alpha_low[k*CHAR_W +: CHAR_W];
            end else begin
                sym[k] = r_alpha_high[(k-8)*CHAR_W +: CHAR_W];
            end
        end
    end

    // alphabet check: length in range, every used symbol printable and not
    // a sign, no symbol repeated
    always_comb begin
        base_ok = (r_alpha_len >= LEN_W'(2)) && (r_alpha_len <= LEN_W'(MAX_BASE));
        for (int i = 0; i < MAX_BASE; i++) begin
            if (LEN_W'(i) < r_alpha_len) begin
                if (sym[i] <= CH_SPACE || sym[i] >= CH_DEL ||
                    sym[i] == CH_PLUS || sym[i] == CH_MINUS) begin
                    base_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_BASE; j++) begin
                    if (LEN_W'(j) < r_alpha_len && sym[j] == sym[i]) begin
                        base_ok = 1'b0;
                    end
                end
            end
        end
    end

    // symbol lookup, lowest matching index wins
    always_comb begin
        dig_hit = 1'b0;
        dig_val = '0;
        for (int i = MAX_BASE - 1; i >= 0; i--) begin
            if (LEN_W'(i) < r_alpha_len && sym[i] == r_in_char) begin
                dig_hit = 1'b1;
                dig_val = DIG_W'(i);
            end
        end
    end

    assign is_ws = (r_in_char >= CH_TAB && r_in_char <= CH_CR) || (r_in_char == CH_SPACE);

    // phase walk for the character in the input register
    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        if (n_phase == PH_SPACE && !is_ws) begin
            n_phase = PH_SIGN;
        end
        if (n_phase == PH_SIGN) begin
            if (r_in_char == CH_MINUS) begin
                n_neg = ~n_neg;
            end else if (r_in_char != CH_PLUS) begin
                n_phase = PH_DIGIT;
            end
        end
        if (n_phase == PH_DIGIT) begin
            if (dig_hit) begin
                n_acc = VALUE_W'(r_acc * {{(VALUE_W-LEN_W){1'b0}}, r_alpha_len})
                      + VALUE_W'(dig_val);
            end else begin
                n_phase = PH_DONE;
            end
        end
    end

    // a last character needs room in the result register
    assign advance = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_low  <= '0;
            r_alpha_high <= '0;
            r_alpha_len  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALPHA_LOW:  r_alpha_low  <= i_cfg_data;
                CFG_ALPHA_HIGH: r_alpha_high <= i_cfg_data;
                CFG_ALPHA_LEN:  r_alpha_len  <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_char <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else if (advance) begin
            if (r_in_last) begin
                r_phase <= PH_SPACE;
                r_neg   <= 1'b0;
                r_acc   <= '0;
            end else begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in_last) begin
            r_out_ok <= base_ok;
            if (!base_ok) begin
                r_out_value <= '0;
            end else if (n_neg) begin
                r_out_value <= VALUE_W'(0) - n_acc;
            end else begin
                r_out_value <= n_acc;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_ok;

endmodule

FILE: hdl/rsti_checker.sv
`timescale 1ns / 1ps

module rsti_checker
    import rsti_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_s_axis_tready,
    input logic signed [VALUE_W-1:0] o_m_axis_tdata,
    input logic                      o_m_axis_tuser,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a rejected alphabet always reports zero
    a_bad_base_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("nonzero value with bad base");

    // with the result register empty nothing holds back the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty result register");

    // a stalled result transfer keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

endmodule

bind radix_string_to_integer_core rsti_checker u_rsti_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready)
);

FILE: tb/sv/radix_result_checker.sv
`timescale 1ns / 1ps

module radix_result_checker
    import rsti_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [CHAR_W-1:0]         i_s_tdata,
    input  logic                      i_s_tlast,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    input  logic signed [VALUE_W-1:0] i_m_tdata,
    input  logic                      i_m_tuser,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data,
    output int                        o_fail_count = 0,
    output int                        o_pending = 0
);

    typedef enum logic [1:0] {
        LEAD_BLANKS,
        READ_SIGN,
        READ_DIGITS,
        IGNORE_REST
    } t_parse_phase;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      base_ok;
    } t_parsed_int;

    t_parsed_int parsed_q[$];

    logic [2*CFG_W-1:0] symbols  = '0;
    logic [LEN_W-1:0]   base_len = '0;
    t_parse_phase       phase_now = LEAD_BLANKS;
    logic               negative  = 1'b0;
    logic [VALUE_W-1:0] acc       = '0;
    int                 fails     = 0;

    function automatic int digit_value(input t_sym c);
        int n;
        int i;
        n = (base_len > SYM_CNT) ? SYM_CNT : int'(base_len);
        for (i = 0; i < n; i++) begin
            if (symbols[i*CHAR_W +: CHAR_W] == c) return i;
        end
        return -1;
    endfunction

    function automatic logic base_is_valid();
        int   n;
        int   i;
        int   j;
        t_sym s;
        n = int'(base_len);
        if (n < 2 || n > MAX_BASE_DEF) return 1'b0;
        for (i = 0; i < n; i++) begin
            s = symbols[i*CHAR_W +: CHAR_W];
            if (s <= CH_SPACE || s >= CH_DEL || s == CH_PLUS || s == CH_MINUS) return 1'b0;
            for (j = i + 1; j < n; j++) begin
                if (symbols[j*CHAR_W +: CHAR_W] == s) return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic parse_char(input t_sym c, input logic last);
        int          d;
        t_parsed_int r;
        if (phase_now == LEAD_BLANKS && !((c >= CH_TAB && c <= CH_CR) || c == CH_SPACE))
            phase_now = READ_SIGN;
        if (phase_now == READ_SIGN) begin
            if (c == CH_PLUS || c == CH_MINUS) begin
                if (c == CH_MINUS) negative = !negative;
            end else begin
                phase_now = READ_DIGITS;
            end
        end
        if (phase_now == READ_DIGITS) begin
            d = digit_value(c);
            if (d >= 0) acc = acc * VALUE_W'(base_len) + VALUE_W'(d);
            else phase_now = IGNORE_REST;
        end
        if (last) begin
            if (base_is_valid()) begin
                r.value   = negative ? -acc : acc;
                r.base_ok = 1'b1;
            end else begin
                r.value   = '0;
                r.base_ok = 1'b0;
            end
            parsed_q.push_back(r);
            phase_now = LEAD_BLANKS;
            negative  = 1'b0;
            acc       = '0;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_parsed_int oldest;
        if (!i_rst_n) begin
            symbols   = '0;
            base_len  = '0;
            phase_now = LEAD_BLANKS;
            negative  = 1'b0;
            acc       = '0;
            parsed_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (parsed_q.size() == 0) begin
                    fails++;
                    $display("%0t unexpected result: expected none, actual value %0d base_ok %0b",
                             $time, i_m_tdata, i_m_tuser);
                end else begin
                    oldest = parsed_q.pop_front();
                    if (i_m_tdata !== oldest.value) begin
                        fails++;
                        $display("%0t value mismatch: expected %0d, actual %0d",
                                 $time, oldest.value, i_m_tdata);
                    end
                    if (i_m_tuser !== oldest.base_ok) begin
                        fails++;
                        $display("%0t base_ok mismatch: expected %0b, actual %0b",
                                 $time, oldest.base_ok, i_m_tuser);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ALPHA_LOW:  symbols[CFG_W-1:0]       = i_cfg_data;
                    CFG_ALPHA_HIGH: symbols[2*CFG_W-1:CFG_W] = i_cfg_data;
                    CFG_ALPHA_LEN:  base_len                 = i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) parse_char(i_s_tdata, i_s_tlast);
        end
        o_pending    <= parsed_q.size();
        o_fail_count <= fails;
    end

endmodule

FILE: tb/sv/radix_string_to_integer_core_test.sv
`timescale 1ns / 1ps

module radix_string_to_integer_core_test;
    import rsti_pkg::*;

    localparam int         ITEM_TARGET   = 1050;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         IDLE_PCT      = 17;
    // keep a margin after the last result before touching the alphabet
    localparam int         SETTLE_CYCLES = 4;
    // index past the register list, the core must ignore it
    localparam logic [1:0] CFG_SPARE     = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic [CHAR_W-1:0]         s_tdata  = '0;
    logic                      s_tlast  = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic signed [VALUE_W-1:0] m_tdata;
    logic                      m_tuser;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [1:0]                cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data  = '0;

    int fail_count;
    int pending;

    // alphabet as last programmed, used to pick digit characters
    logic [2*CFG_W-1:0] cur_symbols = '0;
    logic [LEN_W-1:0]   cur_len     = '0;

    bit no_idle     = 1'b0;
    int items_sent  = 0;
    int cycle_count = 0;

    radix_string_to_integer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    radix_result_checker result_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side backpressure, off during the no-idle stretch
    always @(posedge i_clk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // hard stop in case the core hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("radix_string_to_integer_core test failed");
            $finish;
        end
    end

    // one character transfer; tvalid is left high so back-to-back
    // characters never see a low-then-high in the same step
    task automatic send_char(input t_sym c, input logic last);
        int   gap;
        logic took;
        gap = 0;
        if (!no_idle) begin
            while ($urandom_range(0, 99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        took = 1'b0;
        // ready is sampled mid-cycle, when nothing is changing
        while (!took) begin
            @(negedge i_clk);
            took = s_tready;
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // drop valid, then hold off until every result has been taken
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_alphabet(input logic [2*CFG_W-1:0] syms,
                                    input logic [LEN_W-1:0] len, input bit poke_spare);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ALPHA_LOW;
        cfg_data  <= syms[CFG_W-1:0];
        @(posedge i_clk);
        cfg_index <= CFG_ALPHA_HIGH;
        cfg_data  <= syms[2*CFG_W-1:CFG_W];
        @(posedge i_clk);
        cfg_index <= CFG_ALPHA_LEN;
        cfg_data  <= CFG_W'(len);
        @(posedge i_clk);
        if (poke_spare) begin
            cfg_index <= CFG_SPARE;
            cfg_data  <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        cur_symbols = syms;
        cur_len     = len;
    endtask

    // symbol i of the text lands in byte i
    function automatic logic [2*CFG_W-1:0] text_symbols(input string txt);
        logic [2*CFG_W-1:0] w;
        int                 i;
        w = '0;
        for (i = 0; i < txt.len(); i++) w[i*CHAR_W +: CHAR_W] = txt[i];
        return w;
    endfunction

    // distinct printable symbols in use, random bytes in the unused slots
    function automatic logic [2*CFG_W-1:0] valid_symbols(input int len);
        logic [2*CFG_W-1:0] w;
        bit                 used [0:255];
        int                 s;
        int                 i;
        w = {$urandom, $urandom, $urandom, $urandom};
        for (i = 0; i < 256; i++) used[i] = 1'b0;
        for (i = 0; i < len; i++) begin
            do begin
                s = $urandom_range(33, 126);
            end while (s == CH_PLUS || s == CH_MINUS || used[s]);
            used[s] = 1'b1;
            w[i*CHAR_W +: CHAR_W] = s[CHAR_W-1:0];
        end
        return w;
    endfunction

    // a symbol that makes the base invalid
    function automatic t_sym bad_symbol();
        case ($urandom_range(0, 4))
            0:       return t_sym'($urandom_range(0, 32));
            1:       return CH_DEL;
            2:       return CH_PLUS;
            3:       return CH_MINUS;
            default: return t_sym'($urandom_range(128, 255));
        endcase
    endfunction

    function automatic t_sym any_digit();
        int n;
        int k;
        n = (cur_len > SYM_CNT) ? SYM_CNT : int'(cur_len);
        if (n == 0) return t_sym'($urandom);
        k = $urandom_range(0, n - 1);
        return cur_symbols[k*CHAR_W +: CHAR_W];
    endfunction

    function automatic t_sym space_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : t_sym'(CH_TAB + r);
    endfunction

    function automatic t_sym sign_char();
        return $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
    endfunction

    task automatic send_text(input string txt);
        int i;
        for (i = 0; i < txt.len(); i++) send_char(txt[i], i == txt.len() - 1);
    endtask

    // well-formed: spaces, signs, digits, trailing junk; noisy: any mix
    // leave_open sends a prefix with no last, so the string spans a config change
    task automatic send_number(input bit noisy, input bit leave_open);
        t_sym chars[$];
        int   n;
        int   i;
        if (noisy) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) begin
                case ($urandom_range(0, 3))
                    0:       chars.push_back(space_char());
                    1:       chars.push_back(sign_char());
                    2:       chars.push_back(any_digit());
                    default: chars.push_back(t_sym'($urandom));
                endcase
            end
        end else begin
            repeat ($urandom_range(0, 3)) chars.push_back(space_char());
            repeat ($urandom_range(0, 3)) chars.push_back(sign_char());
            if ($urandom_range(0, 9) == 0) n = 0;
            else if ($urandom_range(0, 3) == 0) n = $urandom_range(5, 12);
            else n = $urandom_range(1, 4);
            repeat (n) chars.push_back(any_digit());
            if (!leave_open) begin
                repeat ($urandom_range(0, 2)) chars.push_back(t_sym'($urandom));
            end
        end
        if (chars.size() == 0) chars.push_back(any_digit());
        for (i = 0; i < chars.size(); i++)
            send_char(chars[i], !leave_open && (i == chars.size() - 1));
    endtask

    initial begin : stimulus
        logic [2*CFG_W-1:0] syms;
        int                 len;
        int                 pos;
        int                 other;
        int                 phase_idx;
        int                 n_strings;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: decimal with whitespace, sign runs and early terminators
        program_alphabet(text_symbols("0123456789"), 10, 1'b1);
        send_text(" \t-+-42");
        send_char(CH_TAB, 1'b0);
        send_char(CH_CR, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char(CH_MINUS, 1'b0);
        send_char("7", 1'b1);
        // backspace is not whitespace, so nothing is parsed
        send_char(8'd8, 1'b0);
        send_char("5", 1'b1);
        // byte zero and a negative byte alone
        send_char(8'h00, 1'b1);
        send_char(8'hff, 1'b1);
        // widest base, value fills all 32 bits and is negated
        program_alphabet(text_symbols("0123456789abcdef"), 16, 1'b0);
        send_text("-ffffffff");

        // random phases, each under its own alphabet
        phase_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    if ($urandom_range(0, 3) == 0) len = $urandom_range(0, 1) ? 2 : 16;
                    else len = $urandom_range(2, 16);
                    syms = valid_symbols(len);
                end
                5: begin
                    len  = $urandom_range(0, 1) ? 10 : 16;
                    syms = text_symbols("0123456789abcdef");
                end
                6: begin
                    // one symbol bad or a duplicate
                    len  = $urandom_range(2, 16);
                    syms = valid_symbols(len);
                    pos  = $urandom_range(0, len - 1);
                    if ($urandom_range(0, 1)) begin
                        syms[pos*CHAR_W +: CHAR_W] = bad_symbol();
                    end else begin
                        other = (pos + $urandom_range(1, len - 1)) % len;
                        syms[pos*CHAR_W +: CHAR_W] = syms[other*CHAR_W +: CHAR_W];
                    end
                end
                7: begin
                    // length too short or past the largest base
                    case ($urandom_range(0, 3))
                        0:       len = 0;
                        1:       len = 1;
                        default: len = $urandom_range(17, 31);
                    endcase
                    syms = valid_symbols(SYM_CNT);
                end
                default: begin
                    syms = {$urandom, $urandom, $urandom, $urandom};
                    len  = $urandom_range(0, 31);
                end
            endcase
            program_alphabet(syms, LEN_W'(len), $urandom_range(0, 7) == 0);

            // one long phase with no idling on either side
            no_idle   = (phase_idx == 2);
            n_strings = no_idle ? 40 : $urandom_range(3, 12);
            repeat (n_strings) send_number($urandom_range(0, 4) == 0, 1'b0);
            if ($urandom_range(0, 3) == 0) send_number(1'b0, 1'b1);
            phase_idx++;
        end
        no_idle = 1'b0;
        // closes a string that may still be open
        send_number(1'b0, 1'b0);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("radix_string_to_integer_core test passed");
        end else begin
            $display("radix_string_to_integer_core test failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/rsti_pkg.sv
hdl/radix_string_to_integer_core.sv
hdl/rsti_checker.sv
tb/sv/radix_result_checker.sv
tb/sv/radix_string_to_integer_core_test.sv
